### rtl/pet_pkg.sv
package pet_pkg;

    // Table geometry
    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 16;
    localparam int SLOT_W  = 6;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [PAGE_W-1:0]  vpage;
        logic [FRAME_W-1:0] frame_number;
    } t_pet_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame_out;
        logic [SLOT_W-1:0]  slot;
    } t_pet_out;

endpackage

### rtl/page_entry_table.sv
// Page entry table: a small fully associative page-to-frame map.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one command:
// lookup, allocate or free, with a page number and, for allocate, a frame.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
// one result per command: status, frame (lookups only) and slot index.
//
// Timing: a command is taken in the idle state, then a single page
// comparator walks the entries, one per cycle, noting the first matching
// valid entry and the first free entry. A final step applies the update
// and loads the output register. The next command is taken in the cycle
// after the result is loaded; the block takes no new command while one
// is still in progress.
//
// Stalls: the result waits in the output register until transferred. If
// a new result is ready while the previous one still waits, the block holds
// in its final step and accepts nothing until the receiver takes the old one.
//
// Reset (synchronous, active low) clears every valid mark, the sequencer
// and the output valid flag; page and frame storage is not cleared.
module page_entry_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pet_pkg::t_pet_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pet_pkg::t_pet_out o_out_data
);
    import pet_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Sequencer and scan state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_pet_in            r_in, n_in;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic [FRAME_W-1:0] r_hit_frame, n_hit_frame;
    logic               r_have_free, n_have_free;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;

    // Entry storage
    logic [PAGE_W-1:0]  r_page  [ENTRIES];
    logic [FRAME_W-1:0] r_frame [ENTRIES];
    logic [ENTRIES-1:0] r_valid, n_valid;

    // Output register
    logic               r_out_valid, n_out_valid;
    t_pet_out           r_out, n_out;

    logic               page_eq;
    logic               commit;
    logic               wr_en;

    // Shared comparator: one entry per cycle
    assign page_eq = (r_page[r_idx] == r_in.vpage);
    assign commit  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_in        = r_in;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_frame = r_hit_frame;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        o_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // Capture the command and start a fresh scan
                    n_in        = i_in_data;
                    n_idx       = '0;
                    n_hit       = 1'b0;
                    n_have_free = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // Keep only the lowest matching and lowest free entry
                if (!r_hit && r_valid[r_idx] && page_eq) begin
                    n_hit       = 1'b1;
                    n_hit_idx   = r_idx;
                    n_hit_frame = r_frame[r_idx];
                end
                if (!r_have_free && !r_valid[r_idx]) begin
                    n_have_free = 1'b1;
                    n_free_idx  = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FINISH: begin
                if (commit) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = ST_NOT_FOUND;
                    n_out.frame_out  = '0;
                    n_out.slot       = '0;
                    case (r_in.cmd)
                        CMD_LOOKUP: begin
                            if (r_hit) begin
                                n_out.status    = ST_DONE;
                                n_out.frame_out = r_hit_frame;
                                n_out.slot      = SLOT_W'(r_hit_idx);
                            end
                        end
                        CMD_ALLOC: begin
                            if (r_hit) begin
                                n_out.status = ST_PRESENT;
                            end else if (r_have_free) begin
                                wr_en                = 1'b1;
                                n_valid[r_free_idx]  = 1'b1;
                                n_out.status         = ST_DONE;
                                n_out.slot           = SLOT_W'(r_free_idx);
                            end else begin
                                n_out.status = ST_FULL;
                            end
                        end
                        CMD_FREE: begin
                            if (r_hit) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_out.status       = ST_DONE;
                                n_out.slot         = SLOT_W'(r_hit_idx);
                            end
                        end
                        default: begin
                            // Unused code: drop, report not found
                            n_out.status = ST_NOT_FOUND;
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_in        <= n_in;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_frame <= n_hit_frame;
        r_have_free <= n_have_free;
        r_free_idx  <= n_free_idx;
        r_out       <= n_out;
        if (wr_en) begin
            r_page[r_free_idx]  <= r_in.vpage;
            r_frame[r_free_idx] <= r_in.frame_number;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A failed operation reports neither a slot nor a frame
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_DONE)) |->
        ((o_out_data.slot == '0) && (o_out_data.frame_out == '0)))
        else $error("failed result carries nonzero slot or frame");

    // A transfer in always starts a scan at entry zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ((r_state == S_SCAN) && (r_idx == '0)))
        else $error("scan did not start at entry zero");

    // A successful allocate leaves its slot marked valid
    a_alloc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_valid[$past(r_free_idx)])
        else $error("allocated slot not marked valid");

    // Result is loaded only when leaving the final step
    a_load_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("result load out of step with sequencer");

endmodule

### dv/tb_page_entry_table.sv
`timescale 1ns / 1ps

module tb_page_entry_table;
    import pet_pkg::*;

    // Command code 3 is not part of the command set; the block must answer it as a miss
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 40;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_pet_in  i_in_data   = '0;
    logic     i_out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_pet_out o_out_data;

    page_entry_table u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Shadow copy of the translation table, updated at each accepted transfer
    logic [PAGE_W-1:0]  tbl_page  [ENTRIES];
    logic [FRAME_W-1:0] tbl_frame [ENTRIES];
    logic               tbl_valid [ENTRIES];

    t_pet_out table_replies_q[$];

    int  errors       = 0;
    int  cmds_sent    = 0;
    int  replies_seen = 0;
    int  status_seen [4];
    int  full_hits    = 0;
    bit  sender_idles = 1'b1;
    bit  sink_idles   = 1'b1;
    int  ready_hold   = 0;
    int  stall_left   = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("timeout: %0d replies still outstanding", table_replies_q.size());
        $display("tb_page_entry_table: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS)
            $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    // Apply one command to the shadow table and return the reply it owes.
    // Only valid slots are ever compared or read.
    function automatic t_pet_out apply_table_cmd(input t_pet_in item);
        t_pet_out res;
        int       hit;
        int       vacant;
        int       i;
        hit    = -1;
        vacant = -1;
        // Walk downward so the lowest-numbered match and vacancy win
        for (i = ENTRIES - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_page[i] == item.vpage)
                hit = i;
            if (!tbl_valid[i])
                vacant = i;
        end
        res.status    = ST_NOT_FOUND;
        res.frame_out = '0;
        res.slot      = '0;
        case (item.cmd)
            CMD_LOOKUP: begin
                if (hit >= 0) begin
                    res.status    = ST_DONE;
                    res.frame_out = tbl_frame[hit];
                    res.slot      = SLOT_W'(hit);
                end
            end
            CMD_ALLOC: begin
                if (hit >= 0) begin
                    res.status = ST_PRESENT;
                end else if (vacant < 0) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_page[vacant]  = item.vpage;
                    tbl_frame[vacant] = item.frame_number;
                    tbl_valid[vacant] = 1'b1;
                    res.status        = ST_DONE;
                    res.slot          = SLOT_W'(vacant);
                end
            end
            CMD_FREE: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    res.status     = ST_DONE;
                    res.slot       = SLOT_W'(hit);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one command and hold it until the block takes it. Called at a
    // rising edge; valid stays high on return so back-to-back commands flow.
    task automatic send_cmd(input logic [1:0] cmd, input logic [PAGE_W-1:0] page,
                            input logic [FRAME_W-1:0] frame);
        t_pet_in  item;
        t_pet_out want;
        item.cmd          = cmd;
        item.vpage        = page;
        item.frame_number = frame;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        // Ready is sampled as it stood just before the edge
        do @(posedge i_clk); while (!o_in_ready);
        want = apply_table_cmd(item);
        table_replies_q = {table_replies_q, want};
        status_seen[want.status]++;
        if (cmd == CMD_ALLOC && want.status == ST_FULL)
            full_hits++;
        cmds_sent++;
    endtask

    // Drop valid and wait until every owed reply has come back
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (table_replies_q.size() != 0);
    endtask

    // Receiver: random stall bursts, plus a long hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold  = ready_hold - 1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  = stall_left - 1;
        end else if (sink_idles && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  = $urandom_range(0, 11);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each reply transfer against the oldest owed reply
    always @(posedge i_clk) begin : check_replies
        t_pet_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            replies_seen++;
            if (table_replies_q.size() == 0) begin
                report_mismatch($sformatf("unexpected reply %h", o_out_data));
            end else begin
                want = table_replies_q.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_out_data.status, want.status));
                if (o_out_data.frame_out !== want.frame_out)
                    report_mismatch($sformatf("frame_out got %h want %h",
                                              o_out_data.frame_out, want.frame_out));
                if (o_out_data.slot !== want.slot)
                    report_mismatch($sformatf("slot got %0d want %0d",
                                              o_out_data.slot, want.slot));
            end
        end
    end

    // Misses on an empty table, and the unused command code
    task automatic test_empty_table();
        send_cmd(CMD_LOOKUP, 20'h00000, 16'hFFFF);
        send_cmd(CMD_FREE,   20'hFFFFF, 16'h0000);
        send_cmd(CMD_UNUSED, 20'h12345, 16'hABCD);
        drain_replies();
    endtask

    // Extreme pages and frames, a refused duplicate, and hits on both
    task automatic test_alloc_lookup();
        send_cmd(CMD_ALLOC,  20'hFFFFF, 16'hFFFF);
        send_cmd(CMD_ALLOC,  20'h00000, 16'h0000);
        send_cmd(CMD_ALLOC,  20'hFFFFF, 16'h5A5A);
        send_cmd(CMD_LOOKUP, 20'hFFFFF, 16'h0000);
        send_cmd(CMD_LOOKUP, 20'h00000, 16'hFFFF);
        drain_replies();
    endtask

    // Fill every slot, hit the full case, then free a middle slot and refill it
    task automatic test_fill_and_refill();
        int i;
        for (i = 2; i < ENTRIES; i++)
            send_cmd(CMD_ALLOC, PAGE_W'(20'hA5A50 + i), FRAME_W'(16'h1000 * i + i));
        send_cmd(CMD_ALLOC,  20'h55555, 16'hAAAA);
        send_cmd(CMD_FREE,   PAGE_W'(20'hA5A53), 16'h0000);
        send_cmd(CMD_ALLOC,  20'h55555, 16'hAAAA);
        send_cmd(CMD_LOOKUP, 20'h55555, 16'h0000);
        drain_replies();
    endtask

    // Receiver holds off for a long stretch while commands keep coming,
    // so the block fills its result stage and stalls its input.
    task automatic test_backpressure();
        int i;
        sender_idles = 1'b0;
        ready_hold   = HOLD_CYCLES;
        for (i = 0; i < 16; i++)
            send_cmd(2'($urandom_range(0, 2)), PAGE_W'(20'hA5A50 + $urandom_range(0, 9)),
                     16'($urandom));
        drain_replies();
        sender_idles = 1'b1;
    endtask

    // Random mix over a small page pool so hits, duplicates and the full case recur
    task automatic test_random_mix(input int count);
        logic [PAGE_W-1:0] pool [12];
        logic [PAGE_W-1:0] page;
        logic [1:0]        cmd;
        int                resident [ENTRIES];
        int                n_res;
        int                r;
        int                i;
        int                k;
        pool[0] = '0;
        pool[1] = '1;
        for (i = 2; i < 12; i++)
            pool[i] = PAGE_W'($urandom);
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      cmd = CMD_LOOKUP;
            else if (r < 65) cmd = CMD_ALLOC;
            else if (r < 93) cmd = CMD_FREE;
            else             cmd = CMD_UNUSED;
            n_res = 0;
            for (i = 0; i < ENTRIES; i++)
                if (tbl_valid[i]) begin
                    resident[n_res] = i;
                    n_res++;
                end
            r = $urandom_range(0, 99);
            // Frees and lookups lean on resident pages; allocs lean on the pool
            if (n_res > 0 && r < ((cmd == CMD_ALLOC) ? 25 : 50))
                page = tbl_page[resident[$urandom_range(0, n_res - 1)]];
            else if (r < 85)
                page = pool[$urandom_range(0, 11)];
            else
                page = PAGE_W'($urandom);
            send_cmd(cmd, page, FRAME_W'($urandom));
        end
        drain_replies();
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_alloc_lookup();
        test_fill_and_refill();
        test_backpressure();
        test_random_mix(1000);
        // Last stretch runs at full rate on both sides
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        test_random_mix(200);

        // Catch any stray reply after the last expected one
        repeat (ENTRIES + 12) @(posedge i_clk);

        $display("summary: %0d commands, %0d replies; %0d done, %0d not found, %0d present",
                 cmds_sent, replies_seen, status_seen[ST_DONE], status_seen[ST_NOT_FOUND],
                 status_seen[ST_PRESENT]);
        $display("summary: %0d table-full refusals, %0d mismatches, long output hold-off run",
                 full_hits, errors);
        if (errors == 0 && table_replies_q.size() == 0)
            $display("tb_page_entry_table: clean");
        else
            $display("tb_page_entry_table: errors");
        $finish;
    end

endmodule
